// ===== src/pqrr_pkg.sv =====
// Package for the priority quantum round-robin core: payload types, FSM states, constants.
// No dependencies.
package pqrr_pkg;

    localparam int unsigned MAX_PROCS_DEF = 64;
    localparam logic [15:0] QUANTUM_RESET = 16'd10;

    typedef struct packed {
        logic [15:0] burst_len;
        logic [1:0]  priority_level;
        logic [15:0] arrive_tk;
        logic        last;
    } t_req;

    typedef struct packed {
        logic [5:0]  proc_index;
        logic [22:0] wait_tk;
        logic [22:0] turn_tk;
        logic [22:0] switch_cnt;
        logic [15:0] idle_tk;
        logic [28:0] total_waiting;
        logic [28:0] total_turnaround;
        logic        last_result;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PREP,
        ST_RD,
        ST_EXEC,
        ST_PASS,
        ST_SUM,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // store request at load pointer
        logic prep;      // latch quanta, zero idx
        logic rd;        // read entry idx
        logic exec;      // execute slice for entry idx
        logic pass_end;  // end of pass bookkeeping
        logic sum;       // accumulate sums at idx
        logic emit;      // drive result at idx
        logic clr;       // return to reset batch state
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic idx_last;   // idx is last loaded entry
        logic progress;   // clock moved during pass
        logic pending;    // some entry unfinished
        logic empty;      // nothing loaded
    } t_sts;

endpackage

// ===== src/pqrr_ctrl.sv =====
// Controller FSM for the priority quantum round-robin core.
// Depends on pqrr_pkg.
module pqrr_ctrl
    import pqrr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_last,
    input  t_sts   i_sts,
    output t_cmd   o_cmd,
    output logic   o_busy,
    output t_state o_state
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_LOAD;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: if (i_start && i_last) n_state = ST_PREP;
            ST_PREP: n_state = ST_RD;
            ST_RD:   n_state = ST_EXEC;
            ST_EXEC: n_state = i_sts.idx_last ? ST_PASS : ST_RD;
            ST_PASS: begin
                if (i_sts.progress || i_sts.pending) n_state = ST_RD;
                else if (i_sts.empty)                n_state = ST_LOAD;
                else                                 n_state = ST_SUM;
            end
            ST_SUM:  if (i_sts.idx_last) n_state = ST_EMIT;
            ST_EMIT: if (i_sts.idx_last) n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_LOAD: o_cmd.load = i_start;
            ST_PREP: o_cmd.prep = 1'b1;
            ST_RD:   o_cmd.rd = 1'b1;
            ST_EXEC: o_cmd.exec = 1'b1;
            ST_PASS: begin
                o_cmd.pass_end = 1'b1;
                o_cmd.clr = !i_sts.progress && !i_sts.pending && i_sts.empty;
            end
            ST_SUM:  o_cmd.sum = 1'b1;
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.clr  = i_sts.idx_last;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy  = (r_state != ST_LOAD);
    assign o_state = r_state;

endmodule

// ===== src/pqrr_dp.sv =====
// Datapath for the priority quantum round-robin core: process stores, clock, counters.
// Depends on pqrr_pkg.
module pqrr_dp
    import pqrr_pkg::*;
#(
    parameter int unsigned MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_req        i_req,
    input  logic [15:0] i_quantum,
    output t_sts        o_sts,
    output logic        o_res_valid,
    output t_rsp        o_res
);

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);

    // per-process memories
    logic [15:0] m_rem  [MAX_PROCS];
    logic [15:0] m_orig [MAX_PROCS];
    logic [1:0]  m_pri  [MAX_PROCS];
    logic [15:0] m_arr  [MAX_PROCS];
    logic [22:0] m_wait [MAX_PROCS];
    logic [22:0] m_turn [MAX_PROCS];
    logic [MAX_PROCS-1:0] r_done;

    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_idx;
    logic [22:0]   r_clk_t, r_start_t;
    logic [22:0]   r_sw;
    logic [15:0]   r_idle;
    logic          r_prev_ok;
    logic [IW-1:0] r_prev;
    logic [16:0]   r_q1, r_q2, r_q3;
    logic [28:0]   r_sum_w, r_sum_t;
    logic          r_sum_d;

    // registered reads
    logic [15:0] r_rd_rem, r_rd_orig, r_rd_arr;
    logic [1:0]  r_rd_pri;
    logic [22:0] r_rd_wait, r_rd_turn;
    logic        r_res_valid;
    t_rsp        r_res;

    logic [IW-1:0] w_ptr;
    assign w_ptr = r_cnt[IW-1:0];
    logic          w_full;
    assign w_full = (r_cnt == CW'(MAX_PROCS));
    logic          w_idx_last;
    assign w_idx_last = (r_idx == IW'(r_cnt - 1'b1)) || (r_cnt == '0);

    // quantum derivation: 4q/5 and 6q/5 by reciprocal multiply
    logic [15:0] w_qc;
    logic [18:0] w_q4, w_q6;
    logic [38:0] w_m4, w_m6;
    assign w_qc = (i_quantum < 16'd2) ? 16'd2 : i_quantum;
    assign w_q4 = {1'b0, w_qc, 2'b00};
    assign w_q6 = {1'b0, w_qc, 2'b00} + {2'b00, w_qc, 1'b0};
    // 838861/2^22 ~ 1/5, exact for numerators below 2^22
    assign w_m4 = {20'd0, w_q4} * 39'd838861;
    assign w_m6 = {20'd0, w_q6} * 39'd838861;

    // slice decision
    logic [1:0]  w_pr;
    logic [16:0] w_qt;
    logic [19:0] w_lhs3, w_rhs3, w_lhs, w_rhs;
    logic        w_elig, w_fin;
    logic [22:0] w_clk_n, w_turn;
    always_comb begin
        w_pr = r_rd_pri;
        case (w_pr)
            2'd3:    w_qt = r_q3;
            2'd2:    w_qt = r_q2;
            default: w_qt = r_q1;
        endcase
        w_lhs3 = {1'b0, r_rd_rem, 3'b000} + {3'b000, r_rd_rem, 1'b0};
        w_rhs3 = {w_qt, 3'b000} + {1'b0, w_qt, 2'b00} + {3'b000, w_qt};
        w_lhs  = {2'b00, r_rd_rem, 2'b00} + {4'd0, r_rd_rem};
        w_rhs  = {1'b0, w_qt, 2'b00} + {2'b00, w_qt, 1'b0};
        w_elig = !r_done[r_idx] && ({7'd0, r_rd_arr} <= r_clk_t);
        if ({1'b0, r_rd_rem} <= w_qt) w_fin = 1'b1;
        else if (w_pr == 2'd3)        w_fin = (w_lhs3 <= w_rhs3);
        else                          w_fin = (w_lhs <= w_rhs);
        w_clk_n = r_clk_t + {6'd0, (w_fin ? {1'b0, r_rd_rem} : w_qt)};
        w_turn  = w_clk_n - {7'd0, r_rd_arr};
    end

    // memory writes and reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            m_rem[w_ptr]  <= i_req.burst_len;
            m_orig[w_ptr] <= i_req.burst_len;
            m_pri[w_ptr]  <= i_req.priority_level;
            m_arr[w_ptr]  <= i_req.arrive_tk;
        end
        if (i_cmd.exec && w_elig) begin
            m_rem[r_idx] <= w_fin ? 16'd0 : (r_rd_rem - w_qt[15:0]);
            if (w_fin) begin
                m_turn[r_idx] <= w_turn;
                m_wait[r_idx] <= w_turn - {7'd0, r_rd_orig};
            end
        end
        r_rd_rem  <= m_rem[r_idx];
        r_rd_orig <= m_orig[r_idx];
        r_rd_pri  <= m_pri[r_idx];
        r_rd_arr  <= m_arr[r_idx];
        r_rd_wait <= m_wait[r_idx];
        r_rd_turn <= m_turn[r_idx];
    end

    // emit index is registered alongside the registered read data
    logic          r_emit_d;
    logic [IW-1:0] r_emit_idx;
    logic          r_emit_last;

    // control registers; run counters are kept until the next batch starts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_idx <= '0; r_done <= '0;
            r_clk_t <= '0; r_start_t <= '0; r_sw <= '0; r_idle <= '0;
            r_prev_ok <= 1'b0; r_prev <= '0;
        end else if (i_cmd.clr) begin
            r_cnt <= '0; r_idx <= '0; r_done <= '0;
        end else begin
            if (i_cmd.load && !w_full) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.prep) begin
                r_q1 <= w_m4[38:22];
                r_q2 <= {1'b0, w_qc};
                r_q3 <= w_m6[38:22];
                r_idx <= '0;
                r_clk_t <= '0;
                r_start_t <= '0;
                r_sw <= '0;
                r_idle <= '0;
                r_prev_ok <= 1'b0;
            end
            if (i_cmd.exec) begin
                if (w_elig) begin
                    r_clk_t <= w_clk_n;
                    if (w_fin) r_done[r_idx] <= 1'b1;
                    if (!r_prev_ok || r_prev != r_idx) r_sw <= r_sw + 1'b1;
                    r_prev_ok <= 1'b1;
                    r_prev <= r_idx;
                end
                r_idx <= w_idx_last ? '0 : r_idx + 1'b1;
            end
            if (i_cmd.pass_end) begin
                r_idx <= '0;
                if (r_clk_t == r_start_t && o_sts.pending) begin
                    r_clk_t <= r_clk_t + 1'b1;
                    r_idle <= r_idle + 1'b1;
                    r_start_t <= r_clk_t + 1'b1;
                end else begin
                    r_start_t <= r_clk_t;
                end
            end
            if (i_cmd.sum) begin
                r_idx <= w_idx_last ? '0 : r_idx + 1'b1;
            end
            if (i_cmd.emit) r_idx <= r_idx + 1'b1;
        end
    end

    // waiting and turnaround sums, cleared when a batch starts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.prep) begin
            r_sum_w <= '0;
            r_sum_t <= '0;
        end else if (r_sum_d) begin
            r_sum_w <= r_sum_w + {6'd0, r_rd_wait};
            r_sum_t <= r_sum_t + {6'd0, r_rd_turn};
        end
    end

    // sum and emit use registered read of the previous index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_d <= 1'b0; r_emit_d <= 1'b0;
        end else begin
            r_sum_d <= i_cmd.sum;
            r_emit_d <= i_cmd.emit;
        end
        r_emit_idx  <= r_idx;
        r_emit_last <= w_idx_last;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_res_valid <= 1'b0;
        else          r_res_valid <= r_emit_d;
        r_res.proc_index       <= 6'(r_emit_idx);
        r_res.wait_tk          <= r_rd_wait;
        r_res.turn_tk          <= r_rd_turn;
        r_res.last_result      <= r_emit_last;
        r_res.switch_cnt       <= r_emit_last ? (r_sw - 1'b1) : '0;
        r_res.idle_tk          <= r_emit_last ? r_idle : '0;
        r_res.total_waiting    <= r_emit_last ? r_sum_w : '0;
        r_res.total_turnaround <= r_emit_last ? r_sum_t : '0;
    end

    // mask of loaded entries
    logic [MAX_PROCS-1:0] lo_mask;
    always_comb begin
        for (int k = 0; k < MAX_PROCS; k++) lo_mask[k] = (CW'(k) < r_cnt);
    end

    assign o_sts.idx_last = w_idx_last;
    assign o_sts.progress = (r_clk_t != r_start_t);
    assign o_sts.pending  = ((~r_done & lo_mask) != '0);
    assign o_sts.empty    = (r_cnt == '0);
    assign o_res_valid    = r_res_valid;
    assign o_res          = r_res;

endmodule

// ===== src/priority_quantum_round_robin_core.sv =====
// Requests load at one per cycle; after the last request a set-up state, then passes of a
// read and an execute state per entry plus a pass state, then summing and emitting over
// the entries. Each result is registered twice after its emit state; results follow back
// to back, and a new batch may load once busy drops. Synchronous active-low reset clears
// the batch and sets base_quantum to 10. Results cannot be stalled by the receiver.
// Top level: controller plus datapath. Depends on pqrr_pkg, pqrr_ctrl, pqrr_dp.
module priority_quantum_round_robin_core
    import pqrr_pkg::*;
#(
    parameter int unsigned MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_res_valid,
    output t_rsp        o_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_quantum;
    t_cmd   w_cmd;
    t_sts   w_sts;
    t_state w_state;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_quantum <= QUANTUM_RESET;
        else if (i_cfg_valid) r_quantum <= i_cfg_data;
    end

    pqrr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_last(i_req.last),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(busy), .o_state(w_state)
    );

    pqrr_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_req(i_req),
        .i_quantum(r_quantum), .o_sts(w_sts), .o_res_valid(o_res_valid), .o_res(o_res)
    );

`ifndef SYNTH
    // requests only accepted while loading
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> (w_state == ST_LOAD)) else $error("accept outside load");
    // results only follow emit, via the emit and result registers
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy, 2)) else $error("result while idle");
    // a final result returns the core to loading
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ST_EMIT && w_sts.idx_last) |=> (w_state == ST_LOAD))
        else $error("emit did not finish");
`endif

endmodule

// ===== verif/priority_quantum_round_robin_core_tb.sv =====
// Self-checking testbench for priority_quantum_round_robin_core: loads batches of process
// requests, predicts per-process waiting/turnaround times and run totals, checks each result.
// Depends on pqrr_pkg and the core RTL.
module priority_quantum_round_robin_core_tb;
    import pqrr_pkg::*;

    localparam int unsigned NPROC = 64;
    localparam int unsigned NO_PROC = 127;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_res_valid;
    t_rsp        o_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    priority_quantum_round_robin_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // scheduler shadow state
    int unsigned sh_remaining [NPROC];
    int unsigned sh_burst     [NPROC];
    int unsigned sh_prio      [NPROC];
    int unsigned sh_arrival   [NPROC];
    bit          sh_done      [NPROC];
    int unsigned sh_wait      [NPROC];
    int unsigned sh_turn      [NPROC];
    int unsigned sh_loaded = 0;
    int unsigned sh_clock = 0;
    int unsigned sh_switches = 0;
    int unsigned sh_idle = 0;
    int unsigned sh_prev = NO_PROC;
    int unsigned sh_base_q = QUANTUM_RESET;

    t_req pending_procs [$];
    t_rsp expected_times [$];
    int   gap_left = 0;
    bit   gaps_on = 1'b1;
    bit   rst_done = 1'b0;
    int   n_errors = 0;
    int   n_checked = 0;
    int   n_batches = 0;

    // round robin over loaded processes until all are done
    task automatic run_schedule();
        int unsigned q, n, t0, b, qt, pr;
        int unsigned quanta [4];
        bit finish, any_open;
        q = (sh_base_q < 2) ? 2 : sh_base_q;
        quanta[0] = (4 * q) / 5;
        quanta[1] = quanta[0];
        quanta[2] = q;
        quanta[3] = (6 * q) / 5;
        n = sh_loaded;
        forever begin
            t0 = sh_clock;
            for (int i = 0; i < n; i++) begin
                if (sh_done[i] || sh_arrival[i] > sh_clock) continue;
                pr = sh_prio[i];
                qt = quanta[pr];
                b = sh_remaining[i];
                if (b <= qt) finish = 1'b1;
                else if (pr == 3) finish = (10 * b <= 13 * qt);
                else finish = (5 * b <= 6 * qt);
                if (finish) begin
                    sh_clock += b;
                    sh_remaining[i] = 0;
                    sh_turn[i] = sh_clock - sh_arrival[i];
                    sh_wait[i] = sh_turn[i] - sh_burst[i];
                    sh_done[i] = 1'b1;
                end else begin
                    sh_clock += qt;
                    sh_remaining[i] = b - qt;
                end
                if (sh_prev != i) sh_switches++;
                sh_prev = i;
            end
            if (sh_clock != t0) continue;
            any_open = 1'b0;
            for (int i = 0; i < n; i++) if (!sh_done[i]) any_open = 1'b1;
            if (!any_open) break;
            sh_clock++;
            sh_idle++;
        end
    endtask

    // take one accepted request; on last, queue the whole batch of results
    task automatic absorb_process(t_req r);
        int unsigned sum_w, sum_t;
        t_rsp e;
        if (sh_loaded < NPROC) begin
            sh_remaining[sh_loaded] = r.burst_len;
            sh_burst[sh_loaded] = r.burst_len;
            sh_prio[sh_loaded] = r.priority_level;
            sh_arrival[sh_loaded] = r.arrive_tk;
            sh_done[sh_loaded] = 1'b0;
            sh_loaded++;
        end
        if (!r.last) return;
        run_schedule();
        sum_w = 0;
        sum_t = 0;
        for (int k = 0; k < sh_loaded; k++) begin
            sum_w += sh_wait[k];
            sum_t += sh_turn[k];
        end
        for (int k = 0; k < sh_loaded; k++) begin
            e = '0;
            e.proc_index = k[5:0];
            e.wait_tk = sh_wait[k][22:0];
            e.turn_tk = sh_turn[k][22:0];
            if (k + 1 == sh_loaded) begin
                e.switch_cnt = 23'(sh_switches - 1);
                e.idle_tk = sh_idle[15:0];
                e.total_waiting = sum_w[28:0];
                e.total_turnaround = sum_t[28:0];
                e.last_result = 1'b1;
            end
            expected_times.push_back(e);
        end
        n_batches++;
        for (int k = 0; k < NPROC; k++) sh_done[k] = 1'b0;
        sh_loaded = 0;
        sh_clock = 0;
        sh_switches = 0;
        sh_idle = 0;
        sh_prev = NO_PROC;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // driver: one request per handshake, random gaps between requests
    always @(posedge i_clk) begin
        if (rst_done) begin
            if (start && !busy) absorb_process(i_req);
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end else if (pending_procs.size() > 0) begin
                    i_req <= pending_procs.pop_front();
                    start <= 1'b1;
                    gap_left <= pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint unsigned e, longint unsigned a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            n_errors++;
        end
    endtask

    // monitor: compare each result against the oldest prediction
    always @(posedge i_clk) begin
        t_rsp e;
        if (rst_done && o_res_valid) begin
            if (expected_times.size() == 0) begin
                $error("result with nothing expected: proc_index %0d", o_res.proc_index);
                n_errors++;
            end else begin
                e = expected_times.pop_front();
                check_field("proc_index", e.proc_index, o_res.proc_index);
                check_field("wait_tk", e.wait_tk, o_res.wait_tk);
                check_field("turn_tk", e.turn_tk, o_res.turn_tk);
                check_field("switch_cnt", e.switch_cnt, o_res.switch_cnt);
                check_field("idle_tk", e.idle_tk, o_res.idle_tk);
                check_field("total_waiting", e.total_waiting, o_res.total_waiting);
                check_field("total_turnaround", e.total_turnaround, o_res.total_turnaround);
                check_field("last_result", e.last_result, o_res.last_result);
                n_checked++;
            end
        end
    end

    function automatic t_req mk(int unsigned b, int unsigned p, int unsigned a, bit l);
        t_req r;
        r.burst_len = b[15:0];
        r.priority_level = p[1:0];
        r.arrive_tk = a[15:0];
        r.last = l;
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_procs.size() > 0 || start || expected_times.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_quantum(logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sh_base_q = v;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random batch: mostly small, sometimes over the store size
    task automatic queue_batch(int unsigned q, bit full_range, inout int n_items);
        int unsigned sz, b, a, bmax;
        sz = ($urandom_range(0, 9) == 0) ? NPROC + 2 : $urandom_range(1, 8);
        bmax = (3 * q > 400) ? 400 : 3 * q;
        for (int k = 0; k < sz; k++) begin
            if (full_range) b = $urandom_range(0, 65535);
            else if ($urandom_range(0, 9) == 0) b = 0;
            else b = $urandom_range(1, bmax);
            a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 60);
            pending_procs.push_back(mk(b, $urandom_range(0, 3), a, k == sz - 1));
        end
        n_items += sz;
    endtask

    // stimulus sequence
    initial begin
        int n_items;
        int unsigned q;
        logic [15:0] q_set [5];
        n_items = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done <= 1'b1;
        @(posedge i_clk);

        // reset quantum: zero burst, fast finishes, priority code zero, late arrival
        pending_procs.push_back(mk(0, 1, 0, 0));
        pending_procs.push_back(mk(12, 2, 0, 0));
        pending_procs.push_back(mk(13, 3, 3, 0));
        pending_procs.push_back(mk(30, 0, 5, 0));
        pending_procs.push_back(mk(25, 1, 200, 1));
        wait_drained();
        // largest quantum with extreme bursts and arrival
        write_quantum(16'hFFFF);
        pending_procs.push_back(mk(65535, 3, 0, 0));
        pending_procs.push_back(mk(65535, 2, 0, 0));
        pending_procs.push_back(mk(65535, 1, 65535, 1));
        wait_drained();
        // smallest quantum, single process
        write_quantum(16'd2);
        pending_procs.push_back(mk(7, 1, 0, 1));
        wait_drained();

        q_set = '{16'd2, 16'd10, 16'd37, 16'hFFFF, 16'd0};
        for (int ph = 0; n_items < 120 || ph < 5; ph++) begin
            q = (ph % 5 == 4) ? $urandom_range(2, 300) : q_set[ph % 5];
            write_quantum(q[15:0]);
            gaps_on = (ph % 3 != 1);
            repeat ($urandom_range(1, 2)) queue_batch(q, q == 16'hFFFF, n_items);
            wait_drained();
        end

        $display("covered %0d batches from %0d random requests, %0d results checked",
                 n_batches, n_items, n_checked);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("timeout with %0d results outstanding", expected_times.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
